### hw/rtl/otba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package otba_pkg;
    localparam int SLOT_COUNT = 64;
    localparam int TASK_COUNT = 8;
    localparam int PROC_COUNT = 64;
    localparam int ADDR_WIDTH = 32;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_W + 1;
    localparam logic [31:0] ALLOC_LIMIT = 32'h0010_0000;

    typedef logic [ADDR_WIDTH-1:0] t_addr;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAIL     = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        CFG_HEAP_BASE = 1'b0,
        CFG_HEAP_SIZE = 1'b1
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_BUILD,
        S_AFIND_RD,
        S_AFIND_CHK,
        S_ASPARE_RD,
        S_ASPARE_CHK,
        S_AWR_SPARE,
        S_AWR_HIT,
        S_FFIND_RD,
        S_FFIND_CHK,
        S_FWR_REL,
        S_MCUR_RD,
        S_MCUR_LATCH,
        S_MSCAN_RD,
        S_MSCAN_CHK,
        S_MWR_A,
        S_MWR_B,
        S_QSCAN_RD,
        S_QSCAN_CHK,
        S_DONE
    } t_state;

    // one table entry
    typedef struct packed {
        t_addr       base;
        t_addr       size;
        logic signed [7:0] owner;
        logic        used;
    } t_entry;

    localparam int ENTRY_W = 2 * ADDR_WIDTH + 9;

    // slot table access between sequencer and table
    typedef struct packed {
        logic   we;
        t_slot  waddr;
        t_entry wdata;
        t_slot  raddr;
    } t_tbl_req;

    function automatic logic owner_ok(input logic signed [7:0] id);
        owner_ok = ($signed({id[7], id}) >= $signed(9'(-TASK_COUNT))) &&
                   ($signed({id[7], id}) <  $signed(9'(PROC_COUNT)));
    endfunction
endpackage
`default_nettype wire

### hw/rtl/otba_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module otba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/otba_table.sv
`timescale 1ns / 1ps
`default_nettype none
module otba_table (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire otba_pkg::t_tbl_req i_req,
    input  wire logic              i_clear,
    output otba_pkg::t_entry       o_rdata
);
    import otba_pkg::*;

    logic [SLOT_COUNT-1:0] r_valid;
    logic [SLOT_COUNT-1:0] n_valid;
    logic [ENTRY_W-1:0]    w_raw;
    logic                  r_rd_valid;
    t_entry                w_ent;

    otba_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_req.we),
        .i_waddr(i_req.waddr),
        .i_wdata(i_req.wdata),
        .i_raddr(i_req.raddr),
        .o_rdata(w_raw)
    );

    // drop all marks on clear, then mark the entry written in the same cycle
    always_comb begin
        n_valid = i_clear ? '0 : r_valid;
        if (i_req.we) n_valid[i_req.waddr] = 1'b1;
    end

    // track written entries; unwritten ones read as the reset entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
        r_rd_valid <= r_valid[i_req.raddr] && !(!i_rst_n || i_clear);
    end

    assign w_ent = w_raw;

    always_comb begin
        if (r_rd_valid) begin
            o_rdata = w_ent;
        end else begin
            o_rdata = '{base: '0, size: '0, owner: -8'sd1, used: 1'b0};
        end
    end
endmodule
`default_nettype wire

### hw/rtl/otba_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module otba_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire otba_pkg::t_req    i_kind,
    input  wire otba_pkg::t_addr   i_addr,
    input  wire logic [31:0]       i_len,
    input  wire logic signed [7:0] i_owner,
    input  wire otba_pkg::t_addr   i_heap_base,
    input  wire otba_pkg::t_addr   i_heap_size,
    input  wire otba_pkg::t_entry  i_rdata,
    output otba_pkg::t_tbl_req     o_tbl,
    output logic                   o_clear,
    output logic                   o_busy,
    output logic                   o_done,
    output otba_pkg::t_status      o_status,
    output otba_pkg::t_addr        o_grant,
    output logic                   o_owned
);
    import otba_pkg::*;

    t_state r_state, n_state;
    t_req   r_kind;
    t_addr  r_addr;
    logic [31:0] r_len;
    logic signed [7:0] r_owner;
    logic   r_ready_tbl, n_ready_tbl;
    t_cnt   r_n, n_n;
    t_slot  r_hit, n_hit;
    t_slot  r_cur, n_cur;
    t_entry r_hit_e, n_hit_e;
    t_entry r_cur_e, n_cur_e;
    t_entry r_n_e, n_n_e;
    t_status r_status, n_status;
    t_addr  r_grant, n_grant;
    logic   r_owned, n_owned;
    logic   r_mdir, n_mdir;

    // shared adder for the spare split and merge sums
    t_addr  w_sum_a, w_sum_b, w_sum;
    assign w_sum = w_sum_a + w_sum_b;

    logic [32:0] w_qend;
    assign w_qend = {1'b0, r_addr} + {1'b0, r_len};

    t_slot w_n_slot;
    assign w_n_slot = r_n[SLOT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (i_start) n_state = S_DECODE;
            S_DECODE: begin
                unique case (r_kind)
                    REQ_ALLOC: begin
                        if (r_len == '0 || !owner_ok(r_owner) || r_len > ALLOC_LIMIT)
                            n_state = S_DONE;
                        else if (!r_ready_tbl) n_state = S_BUILD;
                        else n_state = S_AFIND_RD;
                    end
                    REQ_FREE:  n_state = (r_addr == '0) ? S_DONE : S_FFIND_RD;
                    REQ_QUERY: n_state = (r_len == '0 || !owner_ok(r_owner)) ?
                                         S_DONE : S_QSCAN_RD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_BUILD:      n_state = S_AFIND_RD;
            S_AFIND_RD:   n_state = (r_n == t_cnt'(SLOT_COUNT)) ? S_DONE : S_AFIND_CHK;
            S_AFIND_CHK:  n_state = (!i_rdata.used && i_rdata.size >= r_len) ?
                                    S_ASPARE_RD : S_AFIND_RD;
            S_ASPARE_RD:  n_state = (r_n == t_cnt'(SLOT_COUNT)) ? S_DONE : S_ASPARE_CHK;
            S_ASPARE_CHK: n_state = (i_rdata.size == '0) ? S_AWR_SPARE : S_ASPARE_RD;
            S_AWR_SPARE:  n_state = S_AWR_HIT;
            S_AWR_HIT:    n_state = S_DONE;
            S_FFIND_RD:   n_state = (r_n == t_cnt'(SLOT_COUNT)) ? S_DONE : S_FFIND_CHK;
            S_FFIND_CHK: begin
                if (i_rdata.used && i_rdata.base == r_addr)
                    n_state = (i_rdata.owner != r_owner) ? S_DONE : S_FWR_REL;
                else n_state = S_FFIND_RD;
            end
            S_FWR_REL:    n_state = S_MSCAN_RD;
            S_MCUR_RD:    n_state = S_MCUR_LATCH;
            S_MCUR_LATCH: n_state = S_MSCAN_RD;
            S_MSCAN_RD:   n_state = (r_n == t_cnt'(SLOT_COUNT)) ? S_DONE : S_MSCAN_CHK;
            S_MSCAN_CHK: begin
                if ((w_n_slot - t_slot'(1)) == r_cur || i_rdata.used ||
                    i_rdata.size == '0)
                    n_state = S_MSCAN_RD;
                else if (i_rdata.base + i_rdata.size == r_cur_e.base ||
                         r_cur_e.base + r_cur_e.size == i_rdata.base)
                    n_state = S_MWR_A;
                else n_state = S_MSCAN_RD;
            end
            S_MWR_A:      n_state = S_MWR_B;
            S_MWR_B:      n_state = r_mdir ? S_MCUR_RD : S_MSCAN_RD;
            S_QSCAN_RD:   n_state = (r_n == t_cnt'(SLOT_COUNT)) ? S_DONE : S_QSCAN_CHK;
            S_QSCAN_CHK:  n_state = (n_owned) ? S_DONE : S_QSCAN_RD;
            S_DONE:       n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // datapath and table control
    always_comb begin
        n_ready_tbl = r_ready_tbl;
        n_n = r_n;
        n_hit = r_hit;
        n_cur = r_cur;
        n_hit_e = r_hit_e;
        n_cur_e = r_cur_e;
        n_n_e = r_n_e;
        n_status = r_status;
        n_grant = r_grant;
        n_owned = r_owned;
        n_mdir = r_mdir;
        o_clear = 1'b0;
        o_tbl = '0;
        o_tbl.raddr = w_n_slot;
        w_sum_a = r_cur_e.base;
        w_sum_b = r_cur_e.size;
        unique case (r_state)
            S_DECODE: begin
                n_status = (r_kind == REQ_QUERY) ? ST_OK : ST_FAIL;
                n_grant = '0;
                n_owned = 1'b0;
                n_n = '0;
            end
            S_BUILD: begin
                o_clear = 1'b1;
                n_ready_tbl = 1'b1;
                o_tbl.we = 1'b1;
                o_tbl.waddr = '0;
                o_tbl.wdata = '{base: i_heap_base, size: i_heap_size,
                                owner: -8'sd1, used: 1'b0};
            end
            S_AFIND_RD, S_FFIND_RD, S_MSCAN_RD, S_QSCAN_RD, S_ASPARE_RD: begin
                o_tbl.raddr = w_n_slot;
            end
            S_AFIND_CHK: begin
                if (!i_rdata.used && i_rdata.size >= r_len) begin
                    n_hit = w_n_slot - t_slot'(1);
                    n_hit_e = i_rdata;
                    n_n = t_cnt'(1);
                end
            end
            S_ASPARE_CHK: begin
                if (i_rdata.size == '0) n_cur = w_n_slot - t_slot'(1);
            end
            S_AWR_SPARE: begin
                w_sum_a = r_hit_e.base;
                w_sum_b = r_len;
                o_tbl.we = 1'b1;
                o_tbl.waddr = r_cur;
                o_tbl.wdata = '{base: w_sum, size: r_hit_e.size - r_len,
                                owner: r_hit_e.owner, used: 1'b0};
            end
            S_AWR_HIT: begin
                o_tbl.we = 1'b1;
                o_tbl.waddr = r_hit;
                o_tbl.wdata = '{base: r_hit_e.base, size: r_len,
                                owner: r_owner, used: 1'b1};
                n_status = ST_OK;
                n_grant = r_hit_e.base;
            end
            S_FFIND_CHK: begin
                if (i_rdata.used && i_rdata.base == r_addr) begin
                    n_status = (i_rdata.owner != r_owner) ? ST_MISMATCH : ST_OK;
                    n_cur = w_n_slot - t_slot'(1);
                    n_cur_e = i_rdata;
                    n_cur_e.used = 1'b0;
                    n_cur_e.owner = -8'sd1;
                end
            end
            S_FWR_REL: begin
                o_tbl.we = 1'b1;
                o_tbl.waddr = r_cur;
                o_tbl.wdata = r_cur_e;
                n_n = '0;
            end
            S_MCUR_RD: o_tbl.raddr = r_cur;
            S_MCUR_LATCH: begin
                n_cur_e = i_rdata;
                n_n = '0;
            end
            S_MSCAN_CHK: begin
                n_n_e = i_rdata;
                n_hit = w_n_slot - t_slot'(1);
                if (!((w_n_slot - t_slot'(1)) == r_cur || i_rdata.used ||
                      i_rdata.size == '0)) begin
                    if (i_rdata.base + i_rdata.size == r_cur_e.base) n_mdir = 1'b1;
                    else n_mdir = 1'b0;
                end
            end
            S_MWR_A: begin
                // grow the surviving block
                o_tbl.we = 1'b1;
                if (r_mdir) begin
                    w_sum_a = r_n_e.size;
                    w_sum_b = r_cur_e.size;
                    o_tbl.waddr = r_hit;
                    o_tbl.wdata = r_n_e;
                    o_tbl.wdata.size = w_sum;
                end else begin
                    w_sum_a = r_cur_e.size;
                    w_sum_b = r_n_e.size;
                    o_tbl.waddr = r_cur;
                    o_tbl.wdata = r_cur_e;
                    o_tbl.wdata.size = w_sum;
                    n_cur_e.size = w_sum;
                end
            end
            S_MWR_B: begin
                // empty the absorbed block
                o_tbl.we = 1'b1;
                o_tbl.waddr = r_mdir ? r_cur : r_hit;
                o_tbl.wdata = r_mdir ? r_cur_e : r_n_e;
                o_tbl.wdata.base = '0;
                o_tbl.wdata.size = '0;
                n_n = '0;
                if (r_mdir) n_cur = r_hit;
            end
            S_QSCAN_CHK: begin
                if (i_rdata.used && i_rdata.owner == r_owner &&
                    r_addr >= i_rdata.base && r_len <= i_rdata.size &&
                    !w_qend[32] ? 1'b1 : (w_qend[31:0] == '0)) begin
                    if (i_rdata.used && i_rdata.owner == r_owner &&
                        r_addr >= i_rdata.base && r_len <= i_rdata.size &&
                        (r_addr - i_rdata.base) <= (i_rdata.size - r_len))
                        n_owned = 1'b1;
                end
            end
            default: ;
        endcase
        // advance the scan index on each read
        if (r_state == S_AFIND_RD || r_state == S_FFIND_RD || r_state == S_MSCAN_RD ||
            r_state == S_QSCAN_RD || r_state == S_ASPARE_RD) begin
            if (r_n != t_cnt'(SLOT_COUNT)) n_n = r_n + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready_tbl <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready_tbl <= n_ready_tbl;
        end
    end

    // hold request and work registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_kind <= i_kind;
            r_addr <= i_addr;
            r_len <= i_len;
            r_owner <= i_owner;
        end
        r_n <= n_n;
        r_hit <= n_hit;
        r_cur <= n_cur;
        r_hit_e <= n_hit_e;
        r_cur_e <= n_cur_e;
        r_n_e <= n_n_e;
        r_status <= n_status;
        r_grant <= n_grant;
        r_owned <= n_owned;
        r_mdir <= n_mdir;
    end

    // outputs
    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_done = (r_state == S_DONE);
        o_status = r_status;
        o_grant = r_grant;
        o_owned = r_owned;
    end
endmodule
`default_nettype wire

### hw/rtl/owner_tagged_block_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  width  content
// s_axis    in   80     req_type, base_addr, clicks, owner
// m_axis    out  40     status, granted_base, is_owned
// cfg       in   1+32   register index, write data
// One request at a time; a slot scan reads one table entry at a time through
// the single read port, in a read state and then a check state. A rejected
// request goes straight to the result; a query scans up to the whole table, an
// allocate scans for a free fit and then for a spare slot, and a free scans for
// the block and then for neighbours, restarting the scan after every merge.
// Reset is synchronous; the table entries are tracked by valid bits.
// The result sits in an output register until taken; m_axis stall holds it.
module owner_tagged_block_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // req_type[1:0], base_addr, clicks, owner, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // status[1:0], granted_base, is_owned, pad
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import otba_pkg::*;

    t_addr r_heap_base, r_heap_size;
    logic  r_out_valid;
    logic [39:0] r_out;
    t_tbl_req w_tbl;
    t_entry   w_rdata;
    logic  w_clear, w_busy, w_done, w_owned;
    t_status w_status;
    t_addr w_grant;
    logic  w_start;

    assign w_start = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !w_busy && !r_out_valid;
    assign o_cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_size <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_HEAP_BASE: r_heap_base <= i_cfg_data;
                CFG_HEAP_SIZE: r_heap_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    otba_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_kind     (t_req'(s_axis_tdata[1:0])),
        .i_addr     (s_axis_tdata[33:2]),
        .i_len      (s_axis_tdata[65:34]),
        .i_owner    (s_axis_tdata[73:66]),
        .i_heap_base(r_heap_base),
        .i_heap_size(r_heap_size),
        .i_rdata    (w_rdata),
        .o_tbl      (w_tbl),
        .o_clear    (w_clear),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_status   (w_status),
        .o_grant    (w_grant),
        .o_owned    (w_owned)
    );

    otba_table u_tbl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_tbl),
        .i_clear(w_clear),
        .o_rdata(w_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_done) r_out <= {5'd0, w_owned, w_grant, w_status};
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out;
endmodule
`default_nettype wire

### hw/rtl/otba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module otba_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept with pending result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("back to back");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
endmodule
bind owner_tagged_block_allocator_core otba_checker u_chk (.*);
`default_nettype wire

### verif/owner_tagged_block_allocator_core_tb.sv
`timescale 1ns / 1ps
module owner_tagged_block_allocator_core_tb;
    import otba_pkg::*;

    typedef struct {
        t_req              kind;
        logic [31:0]       base;
        logic [31:0]       clicks;
        logic signed [7:0] owner;
    } t_request;

    typedef struct {
        t_status     status;
        logic [31:0] grant;
        logic        owned;
    } t_answer;

    typedef struct {
        t_request req;
        logic     typed;
        t_answer  ans;
    } t_row;

    typedef struct {
        logic [31:0] base;
        int          owner;
        logic [31:0] size;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;  // req_type, base_addr, clicks, owner, pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;       // status, granted_base, is_owned, pad
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    owner_tagged_block_allocator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the allocator table
    logic [31:0] tbl_base [SLOT_COUNT];
    logic [31:0] tbl_size [SLOT_COUNT];
    int          tbl_owner [SLOT_COUNT];
    logic        tbl_used [SLOT_COUNT];
    logic        tbl_built;
    logic [31:0] cfg_heap_base, cfg_heap_size;

    t_answer answers_due[$];
    t_grant  live_grants[$];
    int      errs = 0;
    logic    quiet = 1'b0;
    logic    hold_req = 1'b0;
    t_row    rows[$];

    function automatic logic id_ok(int id);
        return id >= -TASK_COUNT && id < PROC_COUNT;
    endfunction

    function automatic void clear_table();
        for (int k = 0; k < SLOT_COUNT; k++) begin
            tbl_base[k] = '0;
            tbl_size[k] = '0;
            tbl_owner[k] = -1;
            tbl_used[k] = 1'b0;
        end
    endfunction

    function automatic t_status alloc_block(logic [31:0] sz, int id, output logic [31:0] g);
        int spare;
        g = '0;
        if (sz == 0 || !id_ok(id) || sz > ALLOC_LIMIT) return ST_FAIL;
        if (!tbl_built) begin
            clear_table();
            tbl_base[0] = cfg_heap_base;
            tbl_size[0] = cfg_heap_size;
            tbl_built = 1'b1;
        end
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (tbl_used[k] || tbl_size[k] < sz) continue;
            spare = 1;
            while (spare < SLOT_COUNT && tbl_size[spare] != 0) spare++;
            if (spare == SLOT_COUNT) return ST_FAIL;
            tbl_base[spare] = tbl_base[k] + sz;
            tbl_size[spare] = tbl_size[k] - sz;
            tbl_owner[spare] = tbl_owner[k];
            tbl_used[spare] = 1'b0;
            tbl_size[k] = sz;
            tbl_owner[k] = id;
            tbl_used[k] = 1'b1;
            g = tbl_base[k];
            return ST_OK;
        end
        return ST_FAIL;
    endfunction

    // coalesce free neighbors, restarting the scan after each merge
    function automatic void coalesce(int cur);
        int n;
        n = 0;
        while (n < SLOT_COUNT) begin
            if (n == cur || tbl_used[n] || tbl_size[n] == 0) begin
                n++;
            end else if (tbl_base[n] + tbl_size[n] == tbl_base[cur]) begin
                tbl_size[n] = tbl_size[n] + tbl_size[cur];
                tbl_base[cur] = '0;
                tbl_size[cur] = '0;
                cur = n;
                n = 0;
            end else if (tbl_base[cur] + tbl_size[cur] == tbl_base[n]) begin
                tbl_size[cur] = tbl_size[cur] + tbl_size[n];
                tbl_base[n] = '0;
                tbl_size[n] = '0;
                n = 0;
            end else begin
                n++;
            end
        end
    endfunction

    function automatic t_status release_block(logic [31:0] a, int id);
        if (a == 0) return ST_FAIL;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            if (tbl_used[k] && tbl_base[k] == a) begin
                if (tbl_owner[k] != id) return ST_MISMATCH;
                tbl_used[k] = 1'b0;
                tbl_owner[k] = -1;
                coalesce(k);
                return ST_OK;
            end
        end
        return ST_FAIL;
    endfunction

    function automatic logic range_owned(logic [31:0] a, logic [31:0] len, int id);
        longint ua, ul, ub, us;
        if (len == 0 || !id_ok(id)) return 1'b0;
        ua = a;
        ul = len;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            ub = tbl_base[k];
            us = tbl_size[k];
            if (tbl_used[k] && tbl_owner[k] == id && ua >= ub && ul <= us &&
                ua + ul <= 64'h1_0000_0000 && ua - ub <= us - ul)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_answer serve_request(t_request r);
        t_answer a;
        a = '{ST_FAIL, '0, 1'b0};
        case (r.kind)
            REQ_ALLOC: begin
                a.status = alloc_block(r.clicks, int'(r.owner), a.grant);
                if (a.status == ST_OK)
                    live_grants.push_back('{a.grant, int'(r.owner), r.clicks});
            end
            REQ_FREE: begin
                a.status = release_block(r.base, int'(r.owner));
                if (a.status == ST_OK)
                    for (int i = 0; i < live_grants.size(); i++)
                        if (live_grants[i].base == r.base) begin
                            live_grants.delete(i);
                            break;
                        end
            end
            REQ_QUERY: begin
                a.status = ST_OK;
                a.owned = range_owned(r.base, r.clicks, int'(r.owner));
            end
            default: ;
        endcase
        return a;
    endfunction

    // offer one request and hold it until the transfer
    task automatic send_request(t_request r, logic typed, t_answer ans);
        t_answer p;
        if (!quiet && $urandom_range(3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tdata = {6'd0, r.owner, r.clicks, r.base, r.kind};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        p = serve_request(r);
        answers_due.push_back(typed ? ans : p);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg idx, logic [31:0] val);
        s_axis_tvalid = 1'b0;
        wait (answers_due.size() == 0);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx == CFG_HEAP_BASE) cfg_heap_base = val;
        else cfg_heap_size = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_request pick_random();
        t_request r;
        int sel, g;
        sel = $urandom_range(99);
        r.base = $urandom;
        r.clicks = $urandom;
        r.owner = 8'($urandom_range(TASK_COUNT + PROC_COUNT - 1) - TASK_COUNT);
        if (sel < 40) begin
            r.kind = REQ_ALLOC;
            r.clicks = ($urandom_range(19) == 0) ? $urandom_range(32'h0010_0001, 32'h000F_FFF0)
                                                  : $urandom_range(1, 32'h400);
        end else if (sel < 75 && live_grants.size() > 0) begin
            g = $urandom_range(live_grants.size() - 1);
            r.kind = REQ_FREE;
            r.base = live_grants[g].base;
            if ($urandom_range(6) != 0) r.owner = 8'(live_grants[g].owner);
        end else if (sel < 95 && live_grants.size() > 0) begin
            g = $urandom_range(live_grants.size() - 1);
            r.kind = REQ_QUERY;
            r.base = live_grants[g].base + $urandom_range(live_grants[g].size - 1);
            r.clicks = $urandom_range(live_grants[g].size + 1);
            if ($urandom_range(5) != 0) r.owner = 8'(live_grants[g].owner);
        end else begin
            // noise: any kind, any owner, any address
            r.kind = t_req'($urandom_range(3));
            r.owner = 8'($urandom);
        end
        return r;
    endfunction

    // result checker and output backpressure
    initial begin
        t_answer e;
        logic [1:0] st;
        logic [31:0] gb;
        logic ow;
        int hold;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                hold = 300;
                while (hold > 0) begin
                    @(negedge i_clk);
                    hold--;
                end
                hold_req = 1'b0;
            end
            m_axis_tready = quiet || ($urandom_range(4) != 0);
            if (!quiet && !m_axis_tready) repeat ($urandom_range(1, 6)) @(negedge i_clk);
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                st = m_axis_tdata[1:0];
                gb = m_axis_tdata[33:2];
                ow = m_axis_tdata[34];
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result st=%0d gb=%h ow=%0d", $time, st, gb, ow);
                    errs++;
                end else begin
                    e = answers_due.pop_front();
                    if (st != e.status || gb != e.grant || ow != e.owned) begin
                        $display("%0t: exp st=%0d gb=%h ow=%0d, got st=%0d gb=%h ow=%0d",
                                 $time, e.status, e.grant, e.owned, st, gb, ow);
                        errs++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer at all
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 100000) begin
                $display("owner_tagged_block_allocator_core_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        t_answer none;
        none = '{ST_OK, '0, 1'b0};
        cfg_heap_base = '0;
        cfg_heap_size = '0;
        tbl_built = 1'b0;
        clear_table();
        // before the table exists, then a grant at address zero
        rows = '{
            '{'{REQ_FREE,  32'h0,        32'h0,        8'sd0},   1, '{ST_FAIL, 0, 0}},
            '{'{REQ_FREE,  32'h5,        32'h1,        8'sd0},   1, '{ST_FAIL, 0, 0}},
            '{'{REQ_QUERY, 32'h0,        32'h0,        8'sd0},   1, '{ST_OK, 0, 0}},
            '{'{REQ_NONE,  32'hFFFFFFFF, 32'hFFFFFFFF, -8'sd128}, 1, '{ST_FAIL, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h0,        8'sd1},   1, '{ST_FAIL, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h0010_0001, 8'sd1},  1, '{ST_FAIL, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h10,       -8'sd9},  1, '{ST_FAIL, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h10,       8'sd64},  1, '{ST_FAIL, 0, 0}},
            '{'{REQ_QUERY, 32'h0,        32'h10,       8'sd127}, 1, '{ST_OK, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h10,       -8'sd8},  1, '{ST_OK, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h0010_0000, 8'sd63}, 1, '{ST_FAIL, 0, 0}},
            '{'{REQ_FREE,  32'h0,        32'h0,        -8'sd8},  1, '{ST_FAIL, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h20,       8'sd5},   1, '{ST_OK, 32'h10, 0}},
            '{'{REQ_FREE,  32'h10,       32'h0,        8'sd6},   1, '{ST_MISMATCH, 0, 0}},
            '{'{REQ_QUERY, 32'h10,       32'h20,       8'sd5},   1, '{ST_OK, 0, 1}},
            '{'{REQ_QUERY, 32'h10,       32'h21,       8'sd5},   0, none},
            '{'{REQ_QUERY, 32'hFFFFFFFF, 32'h2,        8'sd5},   1, '{ST_OK, 0, 0}},
            '{'{REQ_ALLOC, 32'h0,        32'h40,       8'sd0},   0, none},
            '{'{REQ_FREE,  32'h10,       32'h0,        8'sd5},   1, '{ST_OK, 0, 0}},
            '{'{REQ_FREE,  32'h30,       32'h0,        8'sd0},   0, none}
        };
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
        for (int i = 0; i < 9; i++) send_request(rows[i].req, rows[i].typed, rows[i].ans);
        // the table is built from these on the first valid allocate
        write_reg(CFG_HEAP_BASE, 32'h0);
        write_reg(CFG_HEAP_SIZE, 32'h0001_0000);
        for (int i = 9; i < rows.size(); i++)
            send_request(rows[i].req, rows[i].typed, rows[i].ans);
        // later writes must not disturb the built table
        write_reg(CFG_HEAP_SIZE, 32'h0);
        write_reg(CFG_HEAP_BASE, 32'h8000_0000);
        for (int n = 0; n < 900; n++) begin
            if (n == 200) hold_req = 1'b1;
            if (n == 400) begin
                s_axis_tvalid = 1'b0;
                wait (answers_due.size() == 0);
                @(negedge i_clk);
            end
            if (n == 450) write_reg(CFG_HEAP_BASE, 32'h1234_5678);
            if (n == 800) quiet = 1'b1;
            send_request(pick_random(), 1'b0, none);
        end
        s_axis_tvalid = 1'b0;
        wait (answers_due.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errs == 0)
            $display("owner_tagged_block_allocator_core_tb: clean");
        else
            $display("owner_tagged_block_allocator_core_tb: errors");
        $finish;
    end
endmodule
